// ===== rtl/sic_pkg.sv =====
`timescale 1ns / 1ps
package sic_pkg;
  localparam int CW = 16;
  localparam int DW = CW + 1;
  localparam int PW = 2 * DW + 1;
  localparam int QW = CW + 2;
  localparam int AW = PW + DW;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [DW-1:0] diff_t;
  typedef logic signed [PW-1:0] prod_t;

  typedef enum logic [1:0] {
    REL_NONE  = 2'd0,
    REL_CROSS = 2'd1,
    REL_OVER  = 2'd2,
    REL_TOUCH = 2'd3
  } rel_t;
endpackage

// ===== rtl/sic_div.sv =====
`timescale 1ns / 1ps
module sic_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_vld,
  input  logic [sic_pkg::AW-1:0]   in_a,
  input  logic [sic_pkg::PW-1:0]   in_d,
  output logic                     out_vld,
  output logic [sic_pkg::QW-1:0]   out_q
);
  import sic_pkg::*;

  logic [QW:0]        vld_r;
  logic [AW-1:0]      rem_r [QW+1];
  logic [PW-1:0]      den_r [QW+1];
  logic [QW-1:0]      quo_r [QW+1];
  logic [AW-1:0]      rem_nxt [QW];
  logic [QW-1:0]      quo_nxt [QW];
  logic [AW+QW-1:0]   trial [QW];

  always_comb begin
    for (int s = 0; s < QW; s++) begin
      trial[s] = (AW+QW)'(den_r[s]) << (QW - 1 - s);
      if ((AW+QW)'(rem_r[s]) >= trial[s]) begin
        rem_nxt[s] = rem_r[s] - trial[s][AW-1:0];
        quo_nxt[s] = quo_r[s] | (QW'(1) << (QW - 1 - s));
      end else begin
        rem_nxt[s] = rem_r[s];
        quo_nxt[s] = quo_r[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[QW-1:0], in_vld};
    end
    rem_r[0] <= in_a;
    den_r[0] <= in_d;
    quo_r[0] <= '0;
    for (int s = 0; s < QW; s++) begin
      rem_r[s+1] <= rem_nxt[s];
      den_r[s+1] <= den_r[s];
      quo_r[s+1] <= quo_nxt[s];
    end
  end

  assign out_vld = vld_r[QW];
  assign out_q   = quo_r[QW];
endmodule

// ===== rtl/segment_intersection_classify_core.sv =====
`timescale 1ns / 1ps
// channel | ports                          | handshake
// input   | in_seg1_*, in_seg2_*           | start high, busy low
// result  | out_relation, out_first/second | out_valid, one cycle, no stall
// one item per cycle; results come out in the order of their starts
// (each divider is restoring, one quotient bit per stage)
// busy is always low; the receiver cannot stall
// synchronous active-low reset clears all valid bits
module segment_intersection_classify_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  sic_pkg::coord_t     in_seg1_start_x,
  input  sic_pkg::coord_t     in_seg1_start_y,
  input  sic_pkg::coord_t     in_seg1_end_x,
  input  sic_pkg::coord_t     in_seg1_end_y,
  input  sic_pkg::coord_t     in_seg2_start_x,
  input  sic_pkg::coord_t     in_seg2_start_y,
  input  sic_pkg::coord_t     in_seg2_end_x,
  input  sic_pkg::coord_t     in_seg2_end_y,
  output logic                out_valid,
  output logic [1:0]          out_relation,
  output sic_pkg::coord_t     out_first_x,
  output sic_pkg::coord_t     out_first_y,
  output sic_pkg::coord_t     out_second_x,
  output sic_pkg::coord_t     out_second_y
);
  import sic_pkg::*;

  localparam int LAT = QW + 2;

  function automatic diff_t dif(input coord_t a, input coord_t b);
    dif = DW'(a) - DW'(b);
  endfunction

  function automatic logic [1:0] sg(input prod_t v);
    sg = (v == '0) ? 2'b00 : (v[PW-1] ? 2'b11 : 2'b01);
  endfunction

  function automatic prod_t pabs(input prod_t v);
    pabs = v[PW-1] ? -v : v;
  endfunction

  assign busy = 1'b0;

  // stage 1: register inputs and differences
  logic   v1_r;
  coord_t ax1_r, ay1_r, bx1_r, by1_r, cx1_r, cy1_r, ex1_r, ey1_r;
  diff_t  dx_r, dy_r, fxd_r, fyd_r;
  diff_t  cax_r, cay_r, eax_r, eay_r, cbx_r, cby_r, ebx_r, eby_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else v1_r <= start;
    ax1_r <= in_seg1_start_x; ay1_r <= in_seg1_start_y;
    bx1_r <= in_seg1_end_x;   by1_r <= in_seg1_end_y;
    cx1_r <= in_seg2_start_x; cy1_r <= in_seg2_start_y;
    ex1_r <= in_seg2_end_x;   ey1_r <= in_seg2_end_y;
    dx_r  <= dif(in_seg1_end_x, in_seg1_start_x);
    dy_r  <= dif(in_seg1_end_y, in_seg1_start_y);
    fxd_r <= dif(in_seg2_end_x, in_seg2_start_x);
    fyd_r <= dif(in_seg2_end_y, in_seg2_start_y);
    cax_r <= dif(in_seg2_start_x, in_seg1_start_x);
    cay_r <= dif(in_seg2_start_y, in_seg1_start_y);
    eax_r <= dif(in_seg2_end_x, in_seg1_start_x);
    eay_r <= dif(in_seg2_end_y, in_seg1_start_y);
    cbx_r <= dif(in_seg2_start_x, in_seg1_end_x);
    cby_r <= dif(in_seg2_start_y, in_seg1_end_y);
    ebx_r <= dif(in_seg2_end_x, in_seg1_end_x);
    eby_r <= dif(in_seg2_end_y, in_seg1_end_y);
  end

  // stage 2: products, one multiplier per register
  logic  v2_r;
  coord_t ax2_r, ay2_r, bx2_r, by2_r, cx2_r, cy2_r, ex2_r, ey2_r;
  diff_t dx2_r, dy2_r;
  prod_t p_den_a_r, p_den_b_r, p_col_a_r, p_col_b_r;
  prod_t p1a_r, p1b_r, p2a_r, p2b_r, p3a_r, p3b_r, p4a_r, p4b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else v2_r <= v1_r;
    ax2_r <= ax1_r; ay2_r <= ay1_r; bx2_r <= bx1_r; by2_r <= by1_r;
    cx2_r <= cx1_r; cy2_r <= cy1_r; ex2_r <= ex1_r; ey2_r <= ey1_r;
    dx2_r <= dx_r;  dy2_r <= dy_r;
    p_den_a_r <= PW'(dx_r) * PW'(fyd_r);
    p_den_b_r <= PW'(dy_r) * PW'(fxd_r);
    p_col_a_r <= PW'(dx_r) * PW'(cay_r);
    p_col_b_r <= PW'(dy_r) * PW'(cax_r);
    p1a_r <= PW'(cax_r) * PW'(eay_r);
    p1b_r <= PW'(cay_r) * PW'(eax_r);
    p2a_r <= PW'(cbx_r) * PW'(eby_r);
    p2b_r <= PW'(cby_r) * PW'(ebx_r);
    // s3 = cross(a-c, b-c) = cross(b-a, c-a), the same as the collinear form
    p3a_r <= PW'(dx_r) * PW'(cay_r);
    p3b_r <= PW'(dy_r) * PW'(cax_r);
    p4a_r <= PW'(dx_r) * PW'(eay_r);
    p4b_r <= PW'(dy_r) * PW'(eax_r);
  end

  // stage 3: classification, overlap corners, divider operands
  prod_t den_w, col_w, c1, c2, c3, c4, num_w;
  logic [1:0] s1, s2, s3, s4;
  logic box_miss;
  coord_t mnx1, mxx1, mny1, mxy1, mnx2, mxx2, mny2, mxy2;
  coord_t ofx, ofy, osx, osy;
  logic on1;
  logic cross_nxt;
  rel_t rel3_nxt;
  coord_t f3x_nxt, f3y_nxt, s3x_nxt, s3y_nxt;

  always_comb begin
    den_w = p_den_a_r - p_den_b_r;
    col_w = p_col_a_r - p_col_b_r;
    c1 = p1a_r - p1b_r;
    c2 = p2a_r - p2b_r;
    c3 = p3a_r - p3b_r;
    c4 = p4a_r - p4b_r;
    s1 = sg(c1); s2 = sg(c2); s3 = sg(c3); s4 = sg(c4);
    // num = cross(e-c, a-c) = cross(c-a, e-a) = c1
    num_w = c1;
    mnx1 = (ax2_r < bx2_r) ? ax2_r : bx2_r;  mxx1 = (ax2_r < bx2_r) ? bx2_r : ax2_r;
    mny1 = (ay2_r < by2_r) ? ay2_r : by2_r;  mxy1 = (ay2_r < by2_r) ? by2_r : ay2_r;
    mnx2 = (cx2_r < ex2_r) ? cx2_r : ex2_r;  mxx2 = (cx2_r < ex2_r) ? ex2_r : cx2_r;
    mny2 = (cy2_r < ey2_r) ? cy2_r : ey2_r;  mxy2 = (cy2_r < ey2_r) ? ey2_r : cy2_r;
    box_miss = (mxx1 < mnx2) || (mnx1 > mxx2) || (mxy1 < mny2) || (mny1 > mxy2);
    ofx = (mnx1 > mnx2) ? mnx1 : mnx2;
    ofy = (mny1 > mny2) ? mny1 : mny2;
    osx = (mxx1 < mxx2) ? mxx1 : mxx2;
    osy = (mxy1 < mxy2) ? mxy1 : mxy2;
    // low corner of a falling line can miss segment one, so check the line too
    on1 = (ofx >= mnx1) && (ofx <= mxx1) && (ofy >= mny1) && (ofy <= mxy1) &&
          ((PW'(dif(ofx, ax2_r)) * PW'(dy2_r)) == (PW'(dif(ofy, ay2_r)) * PW'(dx2_r)));

    cross_nxt = 1'b0;
    rel3_nxt  = REL_NONE;
    f3x_nxt = '0; f3y_nxt = '0; s3x_nxt = '0; s3y_nxt = '0;
    if (box_miss) begin
      rel3_nxt = REL_NONE;
    end else if (den_w == '0) begin
      if (col_w == '0) begin
        f3x_nxt = ofx; s3x_nxt = osx;
        f3y_nxt = on1 ? ofy : osy;
        s3y_nxt = on1 ? osy : ofy;
        rel3_nxt = (ofx == osx && ofy == osy) ? REL_TOUCH : REL_OVER;
      end
    end else if (!((s1 != 2'b00 && s1 == s2) || (s3 != 2'b00 && s3 == s4))) begin
      cross_nxt = 1'b1;
      f3x_nxt = ax2_r; f3y_nxt = ay2_r;
      rel3_nxt = (s1 != 2'b00 && s2 != 2'b00 && s3 != 2'b00 && s4 != 2'b00)
                 ? REL_CROSS : REL_TOUCH;
    end
  end

  logic  v3_r, cross_r;
  rel_t  rel3_r;
  coord_t f3x_r, f3y_r, s3x_r, s3y_r;
  prod_t ndx_r, ndy_r, num_r, den_r;
  logic  nx_r, ny_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else v3_r <= v2_r;
    cross_r <= cross_nxt;
    rel3_r  <= rel3_nxt;
    f3x_r <= f3x_nxt; f3y_r <= f3y_nxt; s3x_r <= s3x_nxt; s3y_r <= s3y_nxt;
    num_r <= pabs(num_w);
    den_r <= pabs(den_w);
    ndx_r <= PW'(dx2_r);
    ndy_r <= PW'(dy2_r);
    nx_r <= dx2_r[DW-1] ^ num_w[PW-1] ^ den_w[PW-1];
    ny_r <= dy2_r[DW-1] ^ num_w[PW-1] ^ den_w[PW-1];
  end

  // stage 4: scaled numerators |d| * |num|, quotient fits since |num| <= |den|
  logic  v4_r;
  logic [AW-1:0] ax4_r, ay4_r;
  prod_t den4_r;
  logic  nx4_r, ny4_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else v4_r <= v3_r;
    ax4_r <= AW'(pabs(ndx_r)) * AW'(num_r);
    ay4_r <= AW'(pabs(ndy_r)) * AW'(num_r);
    den4_r <= den_r;
    nx4_r <= nx_r; ny4_r <= ny_r;
  end

  logic qx_vld, qy_vld;
  logic [QW-1:0] qx, qy;

  sic_div u_div_x (.clk(clk), .rst_n(rst_n), .in_vld(v4_r), .in_a(ax4_r),
                   .in_d(den4_r), .out_vld(qx_vld), .out_q(qx));
  sic_div u_div_y (.clk(clk), .rst_n(rst_n), .in_vld(v4_r), .in_a(ay4_r),
                   .in_d(den4_r), .out_vld(qy_vld), .out_q(qy));

  // side data travels alongside the divider
  logic [LAT-1:0] dv_r, cr_r, nxd_r, nyd_r;
  rel_t   rd_r  [LAT];
  coord_t dfx_r [LAT];
  coord_t dfy_r [LAT];
  coord_t dsx_r [LAT];
  coord_t dsy_r [LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) dv_r <= '0;
    else dv_r <= {dv_r[LAT-2:0], v3_r};
    cr_r  <= {cr_r[LAT-2:0], cross_r};
    nxd_r <= {nxd_r[LAT-2:0], nx_r};
    nyd_r <= {nyd_r[LAT-2:0], ny_r};
    rd_r[0] <= rel3_r;
    dfx_r[0] <= f3x_r; dfy_r[0] <= f3y_r; dsx_r[0] <= s3x_r; dsy_r[0] <= s3y_r;
    for (int i = 1; i < LAT; i++) begin
      rd_r[i] <= rd_r[i-1];
      dfx_r[i] <= dfx_r[i-1]; dfy_r[i] <= dfy_r[i-1];
      dsx_r[i] <= dsx_r[i-1]; dsy_r[i] <= dsy_r[i-1];
    end
  end

  // output register: apply sign and add start point
  coord_t ox, oy;
  always_comb begin
    ox = dfx_r[LAT-1] + (nxd_r[LAT-1] ? -CW'(qx) : CW'(qx));
    oy = dfy_r[LAT-1] + (nyd_r[LAT-1] ? -CW'(qy) : CW'(qy));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else out_valid <= dv_r[LAT-1];
    out_relation <= rd_r[LAT-1];
    if (cr_r[LAT-1]) begin
      out_first_x <= ox; out_first_y <= oy;
      out_second_x <= ox; out_second_y <= oy;
    end else begin
      out_first_x <= dfx_r[LAT-1]; out_first_y <= dfy_r[LAT-1];
      out_second_x <= dsx_r[LAT-1]; out_second_y <= dsy_r[LAT-1];
    end
  end

  a_div_align: assert property (@(posedge clk) disable iff (!rst_n)
    qx_vld == dv_r[LAT-1] && qy_vld == dv_r[LAT-1])
    else $error("divider out of step with side data");
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_relation == REL_NONE |->
      out_first_x == '0 && out_first_y == '0 && out_second_x == '0 && out_second_y == '0)
    else $error("no relation but nonzero point");
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##(LAT + 4) out_valid)
    else $error("item lost in pipe");
endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import sic_pkg::*;

  typedef struct {
    rel_t   relation;
    coord_t first_x;
    coord_t first_y;
    coord_t second_x;
    coord_t second_y;
  } seg_result_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  coord_t      pts [8];
  logic        out_valid;
  logic [1:0]  out_relation;
  coord_t      out_first_x, out_first_y, out_second_x, out_second_y;

  seg_result_t pending_results [$];
  int          error_count = 0;
  int          sender_idle_pct = 0;

  segment_intersection_classify_core DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_seg1_start_x(pts[0]), .in_seg1_start_y(pts[1]),
    .in_seg1_end_x(pts[2]), .in_seg1_end_y(pts[3]),
    .in_seg2_start_x(pts[4]), .in_seg2_start_y(pts[5]),
    .in_seg2_end_x(pts[6]), .in_seg2_end_y(pts[7]),
    .out_valid(out_valid), .out_relation(out_relation),
    .out_first_x(out_first_x), .out_first_y(out_first_y),
    .out_second_x(out_second_x), .out_second_y(out_second_y)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic longint lmin(longint a, longint b);
    return a < b ? a : b;
  endfunction

  function automatic longint lmax(longint a, longint b);
    return a > b ? a : b;
  endfunction

  function automatic longint xprod(longint ax, longint ay, longint bx, longint by);
    return ax * by - ay * bx;
  endfunction

  function automatic int sgn(longint v);
    return v > 0 ? 1 : (v < 0 ? -1 : 0);
  endfunction

  // truncating scaled step along segment one
  function automatic longint scaled_step(longint d, longint num, longint den);
    longint q;
    if (den == 0 || (num < 0 ? -num : num) > (den < 0 ? -den : den))
      return 0;
    q = (d * num) / den;
    return q;
  endfunction

  function automatic seg_result_t classify_pair(coord_t p [8]);
    longint ax, ay, bx, by, cx, cy, ex, ey, fx, fy, sx, sy, t, num, den;
    int s1, s2, s3, s4;
    seg_result_t r;
    ax = p[0]; ay = p[1]; bx = p[2]; by = p[3];
    cx = p[4]; cy = p[5]; ex = p[6]; ey = p[7];
    fx = 0; fy = 0; sx = 0; sy = 0;
    r.relation = REL_NONE;
    if (lmax(ax, bx) < lmin(cx, ex) || lmin(ax, bx) > lmax(cx, ex) ||
        lmax(ay, by) < lmin(cy, ey) || lmin(ay, by) > lmax(cy, ey)) begin
      r.relation = REL_NONE;
    end else if (xprod(bx - ax, by - ay, ex - cx, ey - cy) == 0) begin
      if (xprod(bx - ax, by - ay, cx - ax, cy - ay) == 0) begin
        fx = lmax(lmin(ax, bx), lmin(cx, ex));
        fy = lmax(lmin(ay, by), lmin(cy, ey));
        sx = lmin(lmax(ax, bx), lmax(cx, ex));
        sy = lmin(lmax(ay, by), lmax(cy, ey));
        // swap y when the low corner is off segment one
        if (!(xprod(fx - ax, fy - ay, bx - ax, by - ay) == 0 &&
              lmin(ax, bx) <= fx && lmin(ay, by) <= fy &&
              fx <= lmax(ax, bx) && fy <= lmax(ay, by))) begin
          t = fy; fy = sy; sy = t;
        end
        r.relation = (fx == sx && fy == sy) ? REL_TOUCH : REL_OVER;
      end
    end else begin
      s1 = sgn(xprod(cx - ax, cy - ay, ex - ax, ey - ay));
      s2 = sgn(xprod(cx - bx, cy - by, ex - bx, ey - by));
      s3 = sgn(xprod(ax - cx, ay - cy, bx - cx, by - cy));
      s4 = sgn(xprod(ax - ex, ay - ey, bx - ex, by - ey));
      if (!((s1 != 0 && s1 == s2) || (s3 != 0 && s3 == s4))) begin
        num = xprod(ex - cx, ey - cy, ax - cx, ay - cy);
        den = xprod(ex - cx, ey - cy, ax - bx, ay - by);
        fx = ax + scaled_step(bx - ax, num, den);
        fy = ay + scaled_step(by - ay, num, den);
        sx = fx; sy = fy;
        r.relation = (s1 != 0 && s2 != 0 && s3 != 0 && s4 != 0) ? REL_CROSS : REL_TOUCH;
      end
    end
    r.first_x = coord_t'(fx); r.first_y = coord_t'(fy);
    r.second_x = coord_t'(sx); r.second_y = coord_t'(sy);
    return r;
  endfunction

  // sender gap before each item
  task automatic maybe_idle();
    while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_pair(coord_t p [8]);
    maybe_idle();
    start <= 1'b1;
    for (int i = 0; i < 8; i++) pts[i] <= p[i];
    forever begin
      @(negedge clk);
      if (!busy) break;
      @(posedge clk);
    end
    @(posedge clk);
    pending_results.push_back(classify_pair(p));
  endtask

  task automatic send_coords(int a, int b, int c, int d, int e, int f, int g, int h);
    coord_t p [8];
    p[0] = coord_t'(a); p[1] = coord_t'(b); p[2] = coord_t'(c); p[3] = coord_t'(d);
    p[4] = coord_t'(e); p[5] = coord_t'(f); p[6] = coord_t'(g); p[7] = coord_t'(h);
    send_pair(p);
  endtask

  always @(posedge clk) begin
    seg_result_t exp_r;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected: rel %0d", $time, out_relation);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_relation !== exp_r.relation || out_first_x !== exp_r.first_x ||
            out_first_y !== exp_r.first_y || out_second_x !== exp_r.second_x ||
            out_second_y !== exp_r.second_y) begin
          $display("%0t: expected rel %0d (%0d,%0d)-(%0d,%0d) got rel %0d (%0d,%0d)-(%0d,%0d)",
                   $time, exp_r.relation, exp_r.first_x, exp_r.first_y, exp_r.second_x,
                   exp_r.second_y, out_relation, out_first_x, out_first_y,
                   out_second_x, out_second_y);
          error_count++;
        end
      end
    end
  end

  task automatic test_directed();
    send_coords(0, 0, 4, 4, 0, 4, 4, 0);                 // proper crossing
    send_coords(0, 0, 3, 3, 0, 1, 3, 2);                 // crossing, truncated point
    send_coords(0, 0, 2, 2, 5, 5, 7, 7);                 // disjoint boxes
    send_coords(0, 0, 4, 0, 0, 1, 4, 1);                 // parallel, not collinear
    send_coords(0, 0, 6, 0, 2, 0, 9, 0);                 // collinear overlap
    send_coords(0, 4, 4, 0, 2, 2, 6, -2);                // overlap on falling diagonal
    send_coords(0, 0, 2, 2, 2, 2, 5, 5);                 // collinear touching
    send_coords(0, 0, 4, 0, 2, 0, 2, 3);                 // t junction
    send_coords(0, 0, 4, 4, 4, 4, 8, 0);                 // shared endpoint
    send_coords(3, 3, 3, 3, 0, 0, 6, 6);                 // degenerate point on segment
    send_coords(3, 3, 3, 3, 3, 3, 3, 3);                 // both degenerate, same point
    send_coords(1, 2, 1, 2, 0, 0, 4, 4);                 // degenerate point off line
    send_coords(0, 0, 4, 4, 3, 0, 5, -2);                // boxes meet, no crossing
    send_coords(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
    send_coords(-32768, 0, 32767, 0, 0, -32768, 0, 32767);
    send_coords(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767);
    send_coords(32767, -32768, -32768, 32767, 0, -1, 0, -1);
    send_coords(-32768, -32768, -32768, 32767, -32768, 0, 32767, 1);
    send_coords(-32768, -32767, 32767, 32766, -32767, 32767, 32766, -32768);
    send_coords(-1, -1, -1, -1, 0, 0, 0, 0);
  endtask

  task automatic random_pair();
    coord_t p [8];
    int kind, base_x, base_y, dx, dy, t0, t1, t2, t3, span;
    kind = $urandom_range(99);
    if (kind < 20) begin
      for (int i = 0; i < 8; i++) p[i] = coord_t'($urandom);
    end else if (kind < 55) begin
      // small box around a random origin, hits are frequent
      base_x = $urandom_range(0, 60000) - 30000;
      base_y = $urandom_range(0, 60000) - 30000;
      span = ($urandom_range(3) == 0) ? 2000 : 8;
      for (int i = 0; i < 8; i += 2) begin
        p[i]   = coord_t'(base_x + $urandom_range(0, 2 * span) - span);
        p[i+1] = coord_t'(base_y + $urandom_range(0, 2 * span) - span);
      end
    end else if (kind < 80) begin
      // collinear pair along a random direction
      base_x = $urandom_range(0, 20000) - 10000;
      base_y = $urandom_range(0, 20000) - 10000;
      dx = $urandom_range(0, 40) - 20;
      dy = $urandom_range(0, 40) - 20;
      t0 = $urandom_range(0, 20) - 10; t1 = $urandom_range(0, 20) - 10;
      t2 = $urandom_range(0, 20) - 10; t3 = $urandom_range(0, 20) - 10;
      p[0] = coord_t'(base_x + t0 * dx); p[1] = coord_t'(base_y + t0 * dy);
      p[2] = coord_t'(base_x + t1 * dx); p[3] = coord_t'(base_y + t1 * dy);
      p[4] = coord_t'(base_x + t2 * dx); p[5] = coord_t'(base_y + t2 * dy);
      p[6] = coord_t'(base_x + t3 * dx); p[7] = coord_t'(base_y + t3 * dy);
    end else begin
      // long segments sharing or crossing near a common point
      base_x = $urandom_range(0, 20000) - 10000;
      base_y = $urandom_range(0, 20000) - 10000;
      for (int i = 0; i < 8; i++) p[i] = coord_t'($urandom_range(0, 65535));
      p[$urandom_range(1) * 2]     = coord_t'(base_x);
      p[$urandom_range(1) * 2 + 1] = coord_t'(base_y);
      p[4 + $urandom_range(1) * 2] = coord_t'(base_x);
      p[5 + $urandom_range(1) * 2] = coord_t'(base_y);
    end
    send_pair(p);
  endtask

  task automatic test_random(int idle_pct, int count);
    sender_idle_pct = idle_pct;
    for (int n = 0; n < count; n++) random_pair();
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    for (int i = 0; i < 8; i++) pts[i] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(0, 510);
    test_random(51, 510);
    test_random(38, 510);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (QW + 12) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
